FILE: src/c_escape_sequence_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the C escape sequence decoder
// Concurrent checks clocked on aclk and muted while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// Check that a condition holds at every edge out of reset.
`define CESD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define CESD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (pre) |=> (post)) else $error(msg);

`endif

FILE: src/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg
// Shared types, character codes and helper functions of the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cesd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QLW    = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        MODE_TEXT   = 4'b0001,
        MODE_ESCAPE = 4'b0010,
        MODE_HEX    = 4'b0100,
        MODE_OCTAL  = 4'b1000
    } mode_t;

    // One decoded item: one or two bytes.
    typedef struct packed {
        logic       two;
        logic [7:0] b1;
        logic [7:0] b0;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } push_t;

    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QLW-1:0] level;
    } qstat_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_N:    r = 8'd10;
            CH_T:    r = 8'd9;
            CH_R:    r = 8'd13;
            CH_V:    r = 8'd11;
            CH_F:    r = 8'd12;
            CH_A_LO: r = 8'd7;
            CH_B:    r = 8'd8;
            default: r = c;
        endcase
        return r;
    endfunction

    // Return {valid, value} for a hex digit character.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = 5'd0;
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            r = {1'b1, d[3:0]};
        end else if (c >= CH_A_LO && c <= CH_F_LO) begin
            d = c - CH_A_LO + 8'd10;
            r = {1'b1, d[3:0]};
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            d = c - CH_A_UP + 8'd10;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/cesd_front.sv
// ----------------------------------------------------------------------------
// cesd_front
// Accept raw bytes, track the escape state and push decoded items.
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    input  cesd_pkg::qstat_t qstat,
    output cesd_pkg::push_t  push
);
    import cesd_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       seen_reg, seen_next;

    logic [1:0] nres;
    logic [7:0] r0, r1;
    logic [4:0] hx;
    logic [7:0] acc_oct;
    logic [1:0] cnt_oct;
    logic [7:0] run_val;
    logic       is_oct;
    logic       fire;

    assign s_tready = !qstat.full;
    assign fire     = s_tvalid && s_tready;

    always_comb begin
        hx      = hex_digit(s_tdata);
        is_oct  = (s_tdata >= CH_0) && (s_tdata <= CH_7);
        acc_oct = {acc_reg[4:0], s_tdata[2:0]};
        cnt_oct = cnt_reg + 2'd1;
        run_val = (mode_reg == MODE_HEX && !seen_reg) ? CH_X_LO : acc_reg;

        nres      = 2'd0;
        r0        = 8'd0;
        r1        = 8'd0;
        mode_next = MODE_TEXT;
        acc_next  = 8'd0;
        cnt_next  = 2'd0;
        seen_next = 1'b0;

        if (s_tlast) begin
            // Flush whatever escape is pending and return to reset state.
            unique case (mode_reg)
                MODE_TEXT:   nres = 2'd0;
                MODE_ESCAPE: nres = 2'd1;
                MODE_HEX,
                MODE_OCTAL: begin
                    nres = 2'd1;
                    r0   = run_val;
                end
                default:     nres = 2'd0;
            endcase
        end else begin
            unique case (mode_reg)
                MODE_TEXT: begin
                    if (s_tdata == CH_BSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        nres = 2'd1;
                        r0   = s_tdata;
                    end
                end
                MODE_ESCAPE: begin
                    if (s_tdata == CH_X_LO || s_tdata == CH_X_UP) begin
                        mode_next = MODE_HEX;
                    end else if (is_oct) begin
                        mode_next = MODE_OCTAL;
                        acc_next  = {5'd0, s_tdata[2:0]};
                        cnt_next  = 2'd1;
                    end else begin
                        nres = 2'd1;
                        r0   = simple_escape(s_tdata);
                    end
                end
                MODE_HEX,
                MODE_OCTAL: begin
                    if (mode_reg == MODE_HEX && hx[4]) begin
                        mode_next = MODE_HEX;
                        acc_next  = {acc_reg[3:0], hx[3:0]};
                        seen_next = 1'b1;
                    end else if (mode_reg == MODE_OCTAL && is_oct) begin
                        if (cnt_oct == OCT_MAX_DIGITS) begin
                            nres = 2'd1;
                            r0   = acc_oct;
                        end else begin
                            mode_next = MODE_OCTAL;
                            acc_next  = acc_oct;
                            cnt_next  = cnt_oct;
                        end
                    end else begin
                        // Close the run, then treat the byte as text.
                        r0 = run_val;
                        if (s_tdata == CH_BSLASH) begin
                            nres      = 2'd1;
                            mode_next = MODE_ESCAPE;
                        end else begin
                            nres = 2'd2;
                            r1   = s_tdata;
                        end
                    end
                end
                default: nres = 2'd0;
            endcase
        end
    end

    always_comb begin
        push.valid   = fire && (nres != 2'd0);
        push.data.two = (nres == 2'd2);
        push.data.b0  = r0;
        push.data.b1  = r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
            acc_reg  <= 8'd0;
            cnt_reg  <= 2'd0;
            seen_reg <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            seen_reg <= seen_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/cesd_queue.sv
// ----------------------------------------------------------------------------
// cesd_queue
// Short first-in first-out queue of decoded items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  cesd_pkg::push_t  push,
    input  logic             pop,
    output cesd_pkg::entry_t head,
    output cesd_pkg::qstat_t stat
);
    import cesd_pkg::*;

    entry_t         slot_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QLW-1:0] level_reg;
    logic           do_push, do_pop;

    assign stat.full  = (level_reg == QLW'(QDEPTH));
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;
    assign head       = slot_reg[rptr_reg];

    assign do_push = push.valid && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == QAW'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == QAW'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/cesd_back.sv
// ----------------------------------------------------------------------------
// cesd_back
// Pop decoded items and send them out as one or two output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  cesd_pkg::entry_t head,
    input  cesd_pkg::qstat_t stat,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import cesd_pkg::*;

    logic   valid_reg;
    entry_t ent_reg;
    logic   phase_reg;
    logic   beat_done, finishing;

    assign m_tvalid  = valid_reg;
    assign m_tdata   = phase_reg ? ent_reg.b1 : ent_reg.b0;
    assign m_tlast   = !ent_reg.two || phase_reg;
    assign beat_done = valid_reg && m_tready;
    assign finishing = beat_done && m_tlast;
    assign pop       = !stat.empty && (!valid_reg || finishing);

    always_ff @(posedge aclk) begin
        if (pop) begin
            ent_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
        end else if (finishing) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (beat_done) begin
            phase_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: src/c_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// Decode the raw text of a C string literal into its byte values.
//
//   Channel | Dir | tdata (low bit up)  | tlast        | Role
//   --------+-----+---------------------+--------------+----------------------
//   s_      | in  | [7:0] in_char       | end_of_text  | raw literal bytes
//   m_      | out | [7:0] out_byte      | last_of_run  | decoded bytes
//
// One input beat is taken per cycle while the queue has room; the front
// state machine decides each beat in combinational logic. A beat that yields
// two bytes (the byte that closes a hex or octal run) leaves the back end as
// two output beats, so sustained input rate is one beat per cycle while the
// output side keeps up, and falls to the output rate when the queue of 4 items fills.
// Reset is synchronous on aresetn low and returns the decoder to text mode
// with an empty queue; no clearing pass is needed.
// s_tready drops only while the queue is full; m_ stalls hold the output
// register and back up into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_sequence_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_of_run
);
    import cesd_pkg::*;

    push_t  push;
    qstat_t qstat;
    entry_t head;
    logic   pop;
    logic   first_of_two;

    // Front: accept beats, classify them against the escape state and
    // push one entry per beat that yields any byte.
    cesd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .qstat    (qstat),
        .push     (push)
    );

    // Queue: decouple the front from output stalls.
    cesd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (qstat)
    );

    // Back: split each entry into one or two output beats.
    cesd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // First byte of a two-byte item leaves on this edge.
    assign first_of_two = m_tvalid && m_tready && !m_tlast;

`include "c_escape_sequence_decoder_assert.svh"

    // Never push into a full queue: the front would lose a decoded item.
    `CESD_ASSERT_ALWAYS(a_no_push_full, !(push.valid && qstat.full), "push into full queue")

    // Queue level stays within its depth.
    `CESD_ASSERT_ALWAYS(a_level_range, qstat.level <= QLW'(QDEPTH), "queue level overflow")

    // The first byte of a two-byte item is always followed by the second.
    `CESD_ASSERT_NEXT(a_second_beat, first_of_two, m_tvalid && m_tlast, "second beat missing")

endmodule

`default_nettype wire
